// ===== hw/rtl/sbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial bit deframer package
// Shared widths, constants and the per-request result record.
// ----------------------------------------------------------------------------
package sbd_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] WINDOW_SENTINEL = 8'h01;
    localparam logic [BYTE_W-1:0] LENGTH_RESET    = 8'hff;
    localparam logic [BYTE_W-1:0] COUNT_MAX       = 8'hff;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic              header_seen;
        logic              message_done;
        logic              in_message;
        logic              last_bit;
    } t_result;

endpackage

// ===== hw/rtl/sbd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial bit deframer input stage
// Holds one accepted line bit until the framing logic consumes it.
// ----------------------------------------------------------------------------
module sbd_in_stage (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_bit,
    input  logic i_advance,
    output logic o_valid,
    output logic o_bit
);

    logic r_valid;
    logic r_bit;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_bit   = r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bit <= i_bit;
        end
    end

endmodule

// ===== hw/rtl/sbd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial bit deframer core
// Sync hunting, sentinel byte framing, header parsing and length tracking.
// ----------------------------------------------------------------------------
module sbd_core #(
    parameter int unsigned HEADER_BYTES = 4,
    parameter int unsigned INFO_OFFSET  = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_bit,
    input  logic [sbd_pkg::BYTE_W-1:0] i_sync_byte,
    output sbd_pkg::t_result           o_result
);

    localparam logic [sbd_pkg::BYTE_W-1:0] HeaderCount = sbd_pkg::BYTE_W'(HEADER_BYTES);
    localparam logic [sbd_pkg::BYTE_W-1:0] InfoIndex   = sbd_pkg::BYTE_W'(INFO_OFFSET);
    localparam logic [sbd_pkg::BYTE_W-1:0] BaseLength  = sbd_pkg::BYTE_W'(HEADER_BYTES + 1);

    logic [sbd_pkg::BYTE_W-1:0] r_window;
    logic                       r_receiving;
    logic                       r_header_done;
    logic [sbd_pkg::BYTE_W-1:0] r_byte_count;
    logic [sbd_pkg::BYTE_W-1:0] r_expected_len;
    logic [sbd_pkg::BYTE_W-1:0] r_info_byte;

    logic [sbd_pkg::BYTE_W-1:0] n_window;
    logic                       n_receiving;
    logic                       n_header_done;
    logic [sbd_pkg::BYTE_W-1:0] n_byte_count;
    logic [sbd_pkg::BYTE_W-1:0] n_expected_len;
    logic [sbd_pkg::BYTE_W-1:0] n_info_byte;
    logic                       byte_full;

    always_comb begin
        byte_full      = r_window[sbd_pkg::BYTE_W-1];
        n_window       = {r_window[sbd_pkg::BYTE_W-2:0], i_bit};
        n_receiving    = r_receiving;
        n_header_done  = r_header_done;
        n_byte_count   = r_byte_count;
        n_expected_len = r_expected_len;
        n_info_byte    = r_info_byte;
        o_result       = '0;
        o_result.last_bit = i_bit;

        if (!r_receiving && (n_window == i_sync_byte)) begin
            n_receiving   = 1'b1;
            n_header_done = 1'b0;
            n_byte_count  = '0;
            n_info_byte   = '0;
            byte_full     = 1'b1;
        end

        if (n_receiving && byte_full) begin
            o_result.byte_valid = 1'b1;
            o_result.data_byte  = n_window;
            o_result.byte_index = n_byte_count;
            if (n_byte_count == InfoIndex) begin
                n_info_byte = n_window;
            end
            if (n_byte_count != sbd_pkg::COUNT_MAX) begin
                n_byte_count = n_byte_count + 8'd1;
            end
            n_window = sbd_pkg::WINDOW_SENTINEL;
        end

        if (n_receiving && (n_byte_count >= HeaderCount)) begin
            if (!n_header_done) begin
                n_expected_len = BaseLength +
                    (n_info_byte[sbd_pkg::BYTE_W-1] ?
                     {1'b0, n_info_byte[sbd_pkg::BYTE_W-2:0]} : '0);
                n_header_done  = 1'b1;
            end else if (n_byte_count > n_expected_len) begin
                n_receiving           = 1'b0;
                n_header_done         = 1'b0;
                n_expected_len        = sbd_pkg::LENGTH_RESET;
                o_result.message_done = 1'b1;
            end
        end

        o_result.header_seen = n_header_done;
        o_result.in_message  = n_receiving;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window       <= sbd_pkg::WINDOW_SENTINEL;
            r_receiving    <= 1'b0;
            r_header_done  <= 1'b0;
            r_byte_count   <= '0;
            r_expected_len <= sbd_pkg::LENGTH_RESET;
            r_info_byte    <= '0;
        end else if (i_en) begin
            r_window       <= n_window;
            r_receiving    <= n_receiving;
            r_header_done  <= n_header_done;
            r_byte_count   <= n_byte_count;
            r_expected_len <= n_expected_len;
            r_info_byte    <= n_info_byte;
        end
    end

endmodule

// ===== hw/rtl/sbd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial bit deframer output stage
// Result register that holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module sbd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sbd_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_space,
    output logic             o_valid,
    output sbd_pkg::t_result o_result
);

    logic             r_valid;
    sbd_pkg::t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== hw/rtl/serial_bit_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial bit deframer unit
// Hunts for a sync byte in a serial bit stream and frames the message bytes.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tdata[0] line_bit
// m_axis    out        tuser byte_valid, tlast message_done, tdata fields below
// cfg       in         i_cfg_we with i_cfg_wdata writes sync_byte
//
// Each request passes an input register, then the framing logic, then a
// result register, which holds the result until m_axis takes it.
// One request is accepted every cycle while the result side keeps up.
// Reset is synchronous and clears the framing state and both stages.
// A stall on m_axis holds the result and the input register fills before
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module serial_bit_deframer_unit #(
    parameter int unsigned HEADER_BYTES = 4,
    parameter int unsigned INFO_OFFSET  = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] line_bit, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                        // [16] header_seen, [17] in_message,
                                        // [18] last_bit, [23:19] zero
    output logic        m_axis_tuser,   // [0] byte_valid
    output logic        m_axis_tlast    // message_done
);

    logic [sbd_pkg::BYTE_W-1:0] r_sync_byte;
    logic                       in_valid;
    logic                       in_bit;
    logic                       out_space;
    logic                       advance;
    sbd_pkg::t_result           core_result;
    sbd_pkg::t_result           out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= '0;
        end else if (i_cfg_we) begin
            r_sync_byte <= i_cfg_wdata;
        end
    end

    assign advance = in_valid && out_space;

    sbd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_bit     (s_axis_tdata[0]),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_bit     (in_bit)
    );

    sbd_core #(
        .HEADER_BYTES (HEADER_BYTES),
        .INFO_OFFSET  (INFO_OFFSET)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_bit       (in_bit),
        .i_sync_byte (r_sync_byte),
        .o_result    (core_result)
    );

    sbd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_result),
        .i_ready  (m_axis_tready),
        .o_space  (out_space),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = {5'b0, out_result.last_bit, out_result.in_message,
                           out_result.header_seen, out_result.byte_index,
                           out_result.data_byte};
    assign m_axis_tuser = out_result.byte_valid;
    assign m_axis_tlast = out_result.message_done;

endmodule

// ===== hw/rtl/sbd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial bit deframer checker
// Port level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module sbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result must hold.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A message only ends on a completed byte, and it leaves the block idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tuser && !m_axis_tdata[17] && !m_axis_tdata[16])
        else $error("message end without byte or with state left set");

    // Without a byte, the data and index fields read as zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'h0000)
        else $error("byte fields set without a byte");

    // The sync byte opens a message that is still running afterwards.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser && m_axis_tdata[15:8] == 8'h00 |->
            m_axis_tdata[17] && !m_axis_tdata[16])
        else $error("sync byte without an open message");

endmodule

bind serial_bit_deframer_unit sbd_checker u_sbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
